[hw/rtl/fbfl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fbfl_pkg;

    // Pool geometry
    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int PTR_W = IDX_W + 1;
    localparam int CFG_W = 11;

    localparam logic [CFG_W-1:0] POOL_SIZE_RESET = CFG_W'(DEPTH);
    localparam logic [PTR_W-1:0] LIST_EMPTY      = PTR_W'(DEPTH);

    // Request codes
    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // Response codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Control sequencer
    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_LINK = 1'b1
    } fsm_state_t;

endpackage

`default_nettype wire

[hw/rtl/fbfl_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fbfl_req_if import fbfl_pkg::*; ();

    logic              valid;
    logic              ready;
    action_t           action;
    logic [IDX_W-1:0]  free_index;

    modport source (output valid, output action, output free_index, input ready);
    modport sink   (input valid, input action, input free_index, output ready);

endinterface

`default_nettype wire

[hw/rtl/fbfl_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fbfl_rsp_if import fbfl_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  alloc_index;
    status_t           status;

    modport source (output valid, output alloc_index, output status, input ready);
    modport sink   (input valid, input alloc_index, input status, output ready);

endinterface

`default_nettype wire

[hw/rtl/fixed_block_free_list.sv]
// Channel   Dir  Payload                      Handshake
// req       in   action, free_index           valid / ready
// rsp       out  alloc_index, status          valid / ready
// cfg       in   cfg_wdata (pool_size)        cfg_we, no ready
//
// One request per cycle, but none while the link state runs: an allocation
// served from the freed list registers the next head out of the link memory,
// and the link state loads it into head. Reset clears head, fresh mark, pool
// size and the response valid; the link memory is not cleared, since only
// written entries are ever used. A response waits in its register; a new
// request is taken in the cycle that response is consumed.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list import fbfl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    fbfl_req_if.sink               req,
    fbfl_rsp_if.source             rsp
);

    // Link memory: per freed entry, the head it was pushed onto
    logic [PTR_W-1:0] link_mem [DEPTH];
    logic [PTR_W-1:0] link_rd_reg;

    fsm_state_t        state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  fresh_reg, fresh_next;
    logic [CFG_W-1:0]  pool_size_reg;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  alloc_index_reg, alloc_index_next;
    status_t           status_reg, status_next;

    logic              accept;
    logic              link_we;
    logic [PTR_W-1:0]  active_size;

    // Clamp pool size to the memory depth
    assign active_size = (pool_size_reg > CFG_W'(DEPTH)) ? LIST_EMPTY
                                                         : PTR_W'(pool_size_reg);

    assign req.ready       = (state_reg == FSM_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept          = req.valid && req.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.alloc_index = alloc_index_reg;
    assign rsp.status      = status_reg;

    // Decode request, update list state and load the response
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        fresh_next       = fresh_reg;
        alloc_index_next = alloc_index_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        link_we          = 1'b0;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next   = 1'b1;
                    alloc_index_next = '0;
                    status_next      = ST_OK;
                    unique case (req.action)
                        ACT_ALLOC:
                        begin
                            if (head_reg != LIST_EMPTY)
                            begin
                                alloc_index_next = head_reg[IDX_W-1:0];
                                state_next       = FSM_LINK;
                            end
                            else if (fresh_reg < active_size)
                            begin
                                alloc_index_next = fresh_reg[IDX_W-1:0];
                                fresh_next       = fresh_reg + PTR_W'(1);
                            end
                            else
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        ACT_FREE:
                        begin
                            if ({1'b0, req.free_index} >= active_size)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                link_we   = 1'b1;
                                head_next = {1'b0, req.free_index};
                            end
                        end
                        ACT_CLEAR:
                        begin
                            head_next  = LIST_EMPTY;
                            fresh_next = '0;
                        end
                        default:
                        begin
                            // unused code: answer ok, change nothing
                        end
                    endcase
                end
            end
            FSM_LINK:
            begin
                // advance head to the popped entry's link
                head_next  = link_rd_reg;
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Write link on free, read link of current head on every cycle
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[req.free_index] <= head_reg;
        end
        link_rd_reg <= link_mem[head_reg[IDX_W-1:0]];
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            head_reg      <= LIST_EMPTY;
            fresh_reg     <= '0;
            pool_size_reg <= POOL_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                pool_size_reg <= cfg_wdata;
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        alloc_index_reg <= alloc_index_next;
        status_reg      <= status_next;
    end

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import fbfl_pkg::*;

    typedef struct packed {
        action_t           action;
        logic [IDX_W-1:0]  free_index;
    } pool_request_t;

    typedef struct packed {
        logic [IDX_W-1:0]  alloc_index;
        status_t           status;
    } pool_reply_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;

    fbfl_req_if req_bus ();
    fbfl_rsp_if rsp_bus ();

    fixed_block_free_list u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    // Shadow of the pool state
    logic [CFG_W-1:0]  shadow_pool_size;
    logic [PTR_W-1:0]  shadow_head;
    logic [PTR_W-1:0]  shadow_fresh;
    logic [PTR_W-1:0]  shadow_links [DEPTH];

    pool_request_t     request_backlog [$];
    pool_reply_t       expected_replies [$];

    int                send_gap;
    int                recv_wait;
    int                accepted_count;
    int                fault_count;
    logic              steady_flow;
    logic              rsp_hold;

    // Grant, pop, push or reset the shadow pool for one request
    function automatic pool_reply_t pool_model_step(action_t act, logic [IDX_W-1:0] idx);
        logic [PTR_W-1:0] span;
        pool_reply_t      reply;
        span = (shadow_pool_size > CFG_W'(DEPTH)) ? PTR_W'(DEPTH) : PTR_W'(shadow_pool_size);
        reply.alloc_index = '0;
        reply.status      = ST_OK;
        case (act)
            ACT_ALLOC:
            begin
                if (shadow_head < LIST_EMPTY)
                begin
                    reply.alloc_index = shadow_head[IDX_W-1:0];
                    shadow_head       = shadow_links[shadow_head[IDX_W-1:0]];
                end
                else if (shadow_fresh < span)
                begin
                    reply.alloc_index = shadow_fresh[IDX_W-1:0];
                    shadow_fresh      = shadow_fresh + PTR_W'(1);
                end
                else
                begin
                    reply.status = ST_EMPTY;
                end
            end
            ACT_FREE:
            begin
                if ({1'b0, idx} >= span)
                begin
                    reply.status = ST_RANGE;
                end
                else
                begin
                    shadow_links[idx] = shadow_head;
                    shadow_head       = {1'b0, idx};
                end
            end
            ACT_CLEAR:
            begin
                shadow_head  = LIST_EMPTY;
                shadow_fresh = '0;
            end
            default:
            begin
            end
        endcase
        return reply;
    endfunction

    function automatic int draw_gap();
        return steady_flow ? 0 : int'($urandom_range(0, 17));
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Drive requests from the backlog, predict each one on acceptance
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        pool_request_t next_req;
        if (!rst_n)
        begin
            req_bus.valid      <= 1'b0;
            req_bus.action     <= ACT_ALLOC;
            req_bus.free_index <= '0;
            send_gap = 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                expected_replies.push_back(
                    pool_model_step(req_bus.action, req_bus.free_index));
                accepted_count++;
                send_gap = draw_gap();
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_bus.valid <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    next_req = request_backlog.pop_front();
                    req_bus.valid      <= 1'b1;
                    req_bus.action     <= next_req.action;
                    req_bus.free_index <= next_req.free_index;
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Check each reply against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin : watch_replies
        pool_reply_t want;
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: reply with nothing pending: index %0d status %0d",
                                 $time, rsp_bus.alloc_index, rsp_bus.status);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp_bus.alloc_index !== want.alloc_index ||
                        rsp_bus.status !== want.status)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("%0t: mismatch: want idx %0d st %0d, got idx %0d st %0d",
                                     $time, want.alloc_index, want.status,
                                     rsp_bus.alloc_index, rsp_bus.status);
                    end
                end
                recv_wait = draw_gap();
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
            end
            rsp_bus.ready <= (recv_wait == 0) && !rsp_hold;
        end
    end

    // Hold off replies for a long stretch so the request side backs up
    initial
    begin
        rsp_hold = 1'b0;
        wait (accepted_count >= 450);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    task automatic queue_req(action_t act, logic [IDX_W-1:0] idx);
        pool_request_t item;
        item.action     = act;
        item.free_index = idx;
        request_backlog.push_back(item);
    endtask

    // Wait until every request is answered
    task automatic wait_drained();
        while (request_backlog.size() != 0 || req_bus.valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pool_size(logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        shadow_pool_size = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random mix of allocation runs, free runs and noise
    task automatic random_phase(logic [CFG_W-1:0] value, int count);
        int span;
        int made;
        int run_len;
        int pick;
        wait_drained();
        write_pool_size(value);
        steady_flow = ($urandom_range(0, 3) == 0);
        span = (value > CFG_W'(DEPTH)) ? DEPTH : int'(value);
        made = 0;
        while (made < count)
        begin
            pick    = $urandom_range(0, 99);
            run_len = $urandom_range(1, 12);
            if (pick < 55)
            begin
                repeat (run_len) queue_req(ACT_ALLOC, IDX_W'($urandom));
                made += run_len;
            end
            else if (pick < 88)
            begin
                repeat (run_len)
                begin
                    if (span > 0 && $urandom_range(0, 9) < 8)
                        queue_req(ACT_FREE, IDX_W'($urandom_range(0, span - 1)));
                    else
                        queue_req(ACT_FREE, IDX_W'($urandom_range(0, DEPTH - 1)));
                end
                made += run_len;
            end
            else if (pick < 94)
            begin
                queue_req(ACT_CLEAR, IDX_W'($urandom));
                made++;
            end
            else
            begin
                queue_req(action_t'(2'd3), IDX_W'($urandom));
                made++;
            end
        end
    endtask

    // Reset, directed checks, then random phases
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_bus.valid      = 1'b0;
        req_bus.action     = ACT_ALLOC;
        req_bus.free_index = '0;
        rsp_bus.ready      = 1'b0;
        accepted_count     = 0;
        fault_count        = 0;
        steady_flow        = 1'b0;
        shadow_pool_size   = POOL_SIZE_RESET;
        shadow_head        = LIST_EMPTY;
        shadow_fresh       = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Fresh order, LIFO reuse, top index, unused code, clear
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_ALLOC, '1);
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_FREE, IDX_W'(2));
        queue_req(ACT_FREE, IDX_W'(0));
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_FREE, '1);
        queue_req(ACT_ALLOC, '0);
        queue_req(action_t'(2'd3), '1);
        queue_req(ACT_CLEAR, '1);
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_FREE, IDX_W'(5));
        wait_drained();

        // Zero size: freed entry still granted, then empty and range errors
        write_pool_size('0);
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_FREE, '0);
        queue_req(ACT_FREE, '1);
        wait_drained();

        // Single-entry pool
        write_pool_size(CFG_W'(1));
        queue_req(ACT_CLEAR, '0);
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_FREE, '0);
        queue_req(ACT_FREE, IDX_W'(1));
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_ALLOC, '0);

        random_phase('1, 150);
        random_phase(CFG_W'(8), 100);
        random_phase(CFG_W'(DEPTH), 150);
        random_phase(CFG_W'(3), 90);
        random_phase(CFG_W'($urandom_range(2, 40)), 110);
        random_phase('0, 40);
        random_phase(CFG_W'(1), 70);
        random_phase(CFG_W'(DEPTH - 1), 140);
        random_phase(CFG_W'($urandom_range(1, 2047)), 130);
        random_phase(CFG_W'(16), 100);
        random_phase(CFG_W'(DEPTH), 70);

        // Drain and settle
        while (request_backlog.size() != 0 || req_bus.valid)
            @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        fault_count += expected_replies.size();
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[fixed_block_free_list.f]
hw/rtl/fbfl_pkg.sv
hw/rtl/fbfl_req_if.sv
hw/rtl/fbfl_rsp_if.sv
hw/rtl/fixed_block_free_list.sv
sim/testbench.sv
